// ----- src/lpcp_pkg.sv -----
// Shared constants, types and helper functions for the lidar point camera projection block.
// Used by src/lidar_point_camera_projection.sv; depends on nothing else.
package lpcp_pkg;

	localparam int PIXEL_BITS_DEF = 12;
	localparam int POINT_W        = 24;
	localparam int POINT_FRAC     = 12;
	localparam int NORM_FRAC      = 16;
	localparam int COEF_FRAC      = 14;
	localparam int ROT_FRAC       = 18;
	localparam int INTR_FRAC      = 4;
	localparam int NORM_LIMIT     = 1048575;
	localparam longint RADIAL_LIMIT = 64'sd2147483648;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_ROT0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROT1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROT2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRANS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIST  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INTR  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd7;

	localparam int MODE_INV_BIT  = 32;
	localparam int MODE_KEEP_BIT = 33;
	localparam int MODE_CAM_BIT  = 34;

	// Divider: quotient of 2|c|/z with 22 bits, two bits resolved per stage.
	localparam int DIV_BITS   = 2;
	localparam int Q_W        = 22;
	localparam int DIV_STAGES = Q_W / DIV_BITS;
	localparam int MAG_W      = 29;
	localparam int REM_W      = MAG_W + NORM_FRAC + 1;
	localparam int D_W        = 28;
	localparam int CMP_W      = D_W + Q_W;

	typedef struct packed {
		logic [3*POINT_W-1:0] pt;
		logic                 front;
	} side_t;

	typedef struct packed {
		logic signed [20:0] x;
		logic signed [20:0] y;
	} norm_t;

	typedef struct packed {
		logic signed [28:0] tx;
		logic signed [28:0] ty;
	} tang_t;

	// Arithmetic shift right by s with rounding half away from zero.
	function automatic logic signed [63:0] rnd_haz(input logic signed [63:0] v,
			input int unsigned s);
		logic signed [63:0] h;
		h = 64'sd1 <<< (s - 1);
		return (v + h - (v[63] ? 64'sd1 : 64'sd0)) >>> s;
	endfunction

	function automatic logic [POINT_W-1:0] sat_point(input logic signed [29:0] v);
		if (v > 30'sd8388607)
			return 24'h7FFFFF;
		else if (v < -30'sd8388608)
			return 24'h800000;
		else
			return v[POINT_W-1:0];
	endfunction

endpackage

// ----- src/lidar_point_camera_projection.sv -----
// Lidar point to camera pixel projection: rigid transform, divide by depth, distortion, intrinsics.
// Depends on lpcp_pkg (src/lpcp_pkg.sv).

// One lidar point is accepted per cycle while the output side keeps taking transactions; the
// pipeline depth is set by the 11-stage radix-4 divider that forms x/z and y/z and by the
// chain of registered multiplies for r^2, r^4, r^6, the radial factor and the pixel scaling.
// Stalls on the output side propagate back stage by stage, so empty stages keep filling while
// a result waits. A point whose camera depth is at or below the minimum depth, or whose pixel
// falls outside the image, is a miss: it is dropped unless keep-uncolored is set, in which
// case it leaves with hit, pixel_u and pixel_v at zero. Configuration writes are taken in any
// cycle and must only be made while the pipeline is empty.
module lidar_point_camera_projection #(
	parameter int PIXEL_BITS = lpcp_pkg::PIXEL_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lpcp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lpcp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [3*lpcp_pkg::POINT_W-1:0]      s_tdata,  // point_x, point_y, point_z
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// out_x, out_y, out_z, pixel_u, pixel_v, zero fill
	output logic [((3*lpcp_pkg::POINT_W+2*PIXEL_BITS+7)/8)*8-1:0] m_tdata,
	output logic [0:0]                          m_tuser   // hit
);

	localparam int PW      = lpcp_pkg::POINT_W;
	localparam int TDATA_W = ((3*PW + 2*PIXEL_BITS + 7) / 8) * 8;
	localparam int DS      = lpcp_pkg::DIV_STAGES;

	localparam int ST_IN   = 1;
	localparam int ST_MUL  = 2;
	localparam int ST_CAM  = 3;
	localparam int ST_DIV0 = 4;
	localparam int ST_NORM = ST_DIV0 + DS + 1;
	localparam int ST_SQ   = ST_NORM + 1;
	localparam int ST_R2   = ST_NORM + 2;
	localparam int ST_R2SQ = ST_NORM + 3;
	localparam int ST_R4   = ST_NORM + 4;
	localparam int ST_R6P  = ST_NORM + 5;
	localparam int ST_R6   = ST_NORM + 6;
	localparam int ST_KP   = ST_NORM + 7;
	localparam int ST_RAD  = ST_NORM + 8;
	localparam int ST_DP   = ST_NORM + 9;
	localparam int ST_XD   = ST_NORM + 10;
	localparam int ST_FP   = ST_NORM + 11;
	localparam int ST_PIX  = ST_NORM + 12;
	localparam int NS      = ST_NORM + 13;

	// Configuration registers.
	logic [59:0]               rot_q [3];
	logic [59:0]               trans_q;
	logic [63:0]               dist_q;
	logic [63:0]               intr_q;
	logic [2*PIXEL_BITS-1:0]   image_q;
	logic [34:0]               mode_q;

	logic inverse, keep, camout;
	logic signed [15:0] k1, k2, k3, p1, p2;
	logic [15:0] fx, fy, cx, cy, mind;
	logic [PIXEL_BITS-1:0] img_w, img_h;

	assign inverse = mode_q[lpcp_pkg::MODE_INV_BIT];
	assign keep    = mode_q[lpcp_pkg::MODE_KEEP_BIT];
	assign camout  = mode_q[lpcp_pkg::MODE_CAM_BIT];
	assign k1   = signed'(dist_q[15:0]);
	assign k2   = signed'(dist_q[31:16]);
	assign p1   = signed'(dist_q[47:32]);
	assign p2   = signed'(dist_q[63:48]);
	assign k3   = signed'(mode_q[15:0]);
	assign mind = mode_q[31:16];
	assign fx   = intr_q[15:0];
	assign fy   = intr_q[31:16];
	assign cx   = intr_q[47:32];
	assign cy   = intr_q[63:48];
	assign img_w = image_q[PIXEL_BITS-1:0];
	assign img_h = image_q[2*PIXEL_BITS-1:PIXEL_BITS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= '0;
			rot_q[1] <= '0;
			rot_q[2] <= '0;
			trans_q  <= '0;
			dist_q   <= '0;
			intr_q   <= '0;
			image_q  <= '0;
			mode_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lpcp_pkg::REG_ROT0:  rot_q[0] <= cfg_data[59:0];
				lpcp_pkg::REG_ROT1:  rot_q[1] <= cfg_data[59:0];
				lpcp_pkg::REG_ROT2:  rot_q[2] <= cfg_data[59:0];
				lpcp_pkg::REG_TRANS: trans_q  <= cfg_data[59:0];
				lpcp_pkg::REG_DIST:  dist_q   <= cfg_data;
				lpcp_pkg::REG_INTR:  intr_q   <= cfg_data;
				lpcp_pkg::REG_IMAGE: image_q  <= cfg_data[2*PIXEL_BITS-1:0];
				lpcp_pkg::REG_MODE:  mode_q   <= cfg_data[34:0];
				default: ;
			endcase
		end
	end

	// Pipeline flow control: a stage loads when it is empty or its successor loads.
	logic [NS:1] vld;
	logic [NS:1] go;
	logic        emit;

	always_comb begin
		go[NS] = !vld[NS] || m_tready;
		for (int k = NS - 1; k >= 1; k--)
			go[k] = !vld[k] || go[k+1];
	end

	assign s_tready = go[ST_IN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (go[ST_IN])
				vld[ST_IN] <= s_tvalid;
			for (int k = ST_IN + 1; k < NS; k++)
				if (go[k])
					vld[k] <= vld[k-1];
			if (go[NS])
				vld[NS] <= vld[NS-1] && emit;
		end
	end

	// Stage 1: capture the point and form the transform operands.
	logic signed [PW-1:0] p_s1 [3];
	logic signed [PW:0]   a_s1 [3];

	always_ff @(posedge clk) begin
		if (go[ST_IN]) begin
			for (int j = 0; j < 3; j++) begin
				p_s1[j] <= signed'(s_tdata[PW*j +: PW]);
				a_s1[j] <= inverse
					? 25'(signed'(s_tdata[PW*j +: PW])) - 25'(signed'(trans_q[20*j +: 20]))
					: 25'(signed'(s_tdata[PW*j +: PW]));
			end
		end
	end

	// Stage 2: nine rotation products; the inverse uses the transposed matrix.
	logic signed [44:0]   prod_s2 [3][3];
	logic signed [46:0]   bias_s2 [3];
	logic signed [PW-1:0] p_s2 [3];

	always_ff @(posedge clk) begin
		if (go[ST_MUL]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++)
					prod_s2[i][j] <= inverse
						? 45'(signed'(rot_q[j][20*i +: 20])) * 45'(a_s1[j])
						: 45'(signed'(rot_q[i][20*j +: 20])) * 45'(a_s1[j]);
				bias_s2[i] <= inverse ? 47'sd0
					: 47'(signed'({trans_q[20*i +: 20], 18'b0}));
				p_s2[i] <= p_s1[i];
			end
		end
	end

	// Stage 3: exact sum, rounded once to the point format.
	logic signed [29:0]   c_s3 [3];
	logic signed [PW-1:0] p_s3 [3];

	always_ff @(posedge clk) begin
		if (go[ST_CAM]) begin
			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= 30'(lpcp_pkg::rnd_haz(64'(prod_s2[i][0] + prod_s2[i][1]
					+ prod_s2[i][2] + bias_s2[i]), lpcp_pkg::ROT_FRAC));
				p_s3[i] <= p_s2[i];
			end
		end
	end

	// Stage 4 onward: divider over magnitudes, two quotient bits per stage.
	lpcp_pkg::side_t         side_s [ST_DIV0:ST_PIX];
	logic [lpcp_pkg::REM_W-1:0] rem_x_s [0:DS];
	logic [lpcp_pkg::REM_W-1:0] rem_y_s [0:DS];
	logic [lpcp_pkg::Q_W-1:0]   q_x_s   [0:DS];
	logic [lpcp_pkg::Q_W-1:0]   q_y_s   [0:DS];
	logic [lpcp_pkg::D_W-1:0]   d_s     [0:DS];
	logic [3:0]                 flag_s  [0:DS];  // neg x, neg y, sat x, sat y

	logic signed [29:0] mag_x, mag_y;
	assign mag_x = c_s3[0][29] ? -c_s3[0] : c_s3[0];
	assign mag_y = c_s3[1][29] ? -c_s3[1] : c_s3[1];

	always_ff @(posedge clk) begin
		if (go[ST_DIV0]) begin
			side_s[ST_DIV0].front <= c_s3[2] > signed'(30'(mind));
			side_s[ST_DIV0].pt <= camout
				? {lpcp_pkg::sat_point(c_s3[2]), lpcp_pkg::sat_point(c_s3[1]),
				   lpcp_pkg::sat_point(c_s3[0])}
				: {p_s3[2], p_s3[1], p_s3[0]};
			rem_x_s[0] <= {mag_x[lpcp_pkg::MAG_W-1:0], 17'b0};
			rem_y_s[0] <= {mag_y[lpcp_pkg::MAG_W-1:0], 17'b0};
			q_x_s[0]   <= '0;
			q_y_s[0]   <= '0;
			d_s[0]     <= c_s3[2][lpcp_pkg::D_W-1:0];
			flag_s[0]  <= {c_s3[0][29], c_s3[1][29],
				lpcp_pkg::CMP_W'({mag_x[lpcp_pkg::MAG_W-1:0], 17'b0})
					>= {c_s3[2][lpcp_pkg::D_W-1:0], 22'b0},
				lpcp_pkg::CMP_W'({mag_y[lpcp_pkg::MAG_W-1:0], 17'b0})
					>= {c_s3[2][lpcp_pkg::D_W-1:0], 22'b0}};
		end
		for (int k = ST_DIV0 + 1; k <= ST_PIX; k++)
			if (go[k])
				side_s[k] <= side_s[k-1];
	end

	for (genvar s = 0; s < DS; s++) begin : g_div
		logic [lpcp_pkg::REM_W-1:0] rx_n, ry_n;
		logic [lpcp_pkg::Q_W-1:0]   qx_n, qy_n;

		always_comb begin
			logic [lpcp_pkg::CMP_W-1:0] dsh;
			rx_n = rem_x_s[s];
			ry_n = rem_y_s[s];
			qx_n = q_x_s[s];
			qy_n = q_y_s[s];
			for (int j = 0; j < lpcp_pkg::DIV_BITS; j++) begin
				dsh = lpcp_pkg::CMP_W'(d_s[s])
					<< (lpcp_pkg::Q_W - 1 - lpcp_pkg::DIV_BITS*s - j);
				if (lpcp_pkg::CMP_W'(rx_n) >= dsh) begin
					rx_n = rx_n - lpcp_pkg::REM_W'(dsh);
					qx_n[lpcp_pkg::Q_W - 1 - lpcp_pkg::DIV_BITS*s - j] = 1'b1;
				end
				if (lpcp_pkg::CMP_W'(ry_n) >= dsh) begin
					ry_n = ry_n - lpcp_pkg::REM_W'(dsh);
					qy_n[lpcp_pkg::Q_W - 1 - lpcp_pkg::DIV_BITS*s - j] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (go[ST_DIV0+s+1]) begin
				rem_x_s[s+1] <= rx_n;
				rem_y_s[s+1] <= ry_n;
				q_x_s[s+1]   <= qx_n;
				q_y_s[s+1]   <= qy_n;
				d_s[s+1]     <= d_s[s];
				flag_s[s+1]  <= flag_s[s];
			end
		end
	end

	// Normalized coordinates: round the doubled quotient, saturate, restore the sign.
	logic [lpcp_pkg::Q_W-1:0] rq_x, rq_y;
	logic [20:0]              nm_x, nm_y;
	lpcp_pkg::norm_t          nrm_s [ST_NORM:ST_DP-1];

	assign rq_x = lpcp_pkg::Q_W'((23'(q_x_s[DS]) + 23'd1) >> 1);
	assign rq_y = lpcp_pkg::Q_W'((23'(q_y_s[DS]) + 23'd1) >> 1);
	assign nm_x = (flag_s[DS][1] || rq_x > lpcp_pkg::Q_W'(lpcp_pkg::NORM_LIMIT))
		? 21'(lpcp_pkg::NORM_LIMIT) : rq_x[20:0];
	assign nm_y = (flag_s[DS][0] || rq_y > lpcp_pkg::Q_W'(lpcp_pkg::NORM_LIMIT))
		? 21'(lpcp_pkg::NORM_LIMIT) : rq_y[20:0];

	always_ff @(posedge clk) begin
		if (go[ST_NORM]) begin
			nrm_s[ST_NORM].x <= flag_s[DS][3] ? -signed'(nm_x) : signed'(nm_x);
			nrm_s[ST_NORM].y <= flag_s[DS][2] ? -signed'(nm_y) : signed'(nm_y);
		end
		for (int k = ST_NORM + 1; k < ST_DP; k++)
			if (go[k])
				nrm_s[k] <= nrm_s[k-1];
	end

	// Squares and cross product.
	logic signed [41:0] sqx_s, sqy_s, pxy_s;

	always_ff @(posedge clk) begin
		if (go[ST_SQ]) begin
			sqx_s <= 42'(nrm_s[ST_NORM].x) * 42'(nrm_s[ST_NORM].x);
			sqy_s <= 42'(nrm_s[ST_NORM].y) * 42'(nrm_s[ST_NORM].y);
			pxy_s <= 42'(nrm_s[ST_NORM].x) * 42'(nrm_s[ST_NORM].y);
		end
	end

	logic signed [25:0] xx_s, yy_s;
	logic signed [25:0] xy_s [ST_R2:ST_DP-1];
	logic signed [26:0] r2_s [ST_R2:ST_R6];

	always_ff @(posedge clk) begin
		if (go[ST_R2]) begin
			xx_s <= 26'(lpcp_pkg::rnd_haz(64'(sqx_s), lpcp_pkg::NORM_FRAC));
			yy_s <= 26'(lpcp_pkg::rnd_haz(64'(sqy_s), lpcp_pkg::NORM_FRAC));
			xy_s[ST_R2] <= 26'(lpcp_pkg::rnd_haz(64'(pxy_s), lpcp_pkg::NORM_FRAC));
			r2_s[ST_R2] <= 27'(lpcp_pkg::rnd_haz(64'(sqx_s) + 64'(sqy_s),
				lpcp_pkg::NORM_FRAC));
		end
		for (int k = ST_R2 + 1; k < ST_DP; k++)
			if (go[k])
				xy_s[k] <= xy_s[k-1];
		for (int k = ST_R2 + 1; k <= ST_R6; k++)
			if (go[k])
				r2_s[k] <= r2_s[k-1];
	end

	logic signed [53:0] r2sq_s;
	lpcp_pkg::tang_t    tng_s [ST_R2SQ:ST_DP-1];

	always_ff @(posedge clk) begin
		if (go[ST_R2SQ]) begin
			r2sq_s <= 54'(r2_s[ST_R2]) * 54'(r2_s[ST_R2]);
			tng_s[ST_R2SQ].tx <= 29'(r2_s[ST_R2]) + (29'(xx_s) <<< 1);
			tng_s[ST_R2SQ].ty <= 29'(r2_s[ST_R2]) + (29'(yy_s) <<< 1);
		end
		for (int k = ST_R2SQ + 1; k < ST_DP; k++)
			if (go[k])
				tng_s[k] <= tng_s[k-1];
	end

	logic signed [35:0] r4_s [ST_R4:ST_R6];
	logic signed [61:0] r6p_s;
	logic signed [45:0] r6_s;

	always_ff @(posedge clk) begin
		if (go[ST_R4])
			r4_s[ST_R4] <= 36'(lpcp_pkg::rnd_haz(64'(r2sq_s), lpcp_pkg::NORM_FRAC));
		for (int k = ST_R4 + 1; k <= ST_R6; k++)
			if (go[k])
				r4_s[k] <= r4_s[k-1];
		if (go[ST_R6P])
			r6p_s <= 62'(r4_s[ST_R4]) * 62'(r2_s[ST_R4]);
		if (go[ST_R6])
			r6_s <= 46'(lpcp_pkg::rnd_haz(64'(r6p_s), lpcp_pkg::NORM_FRAC));
	end

	// Radial factor.
	logic signed [43:0] kr2_s;
	logic signed [51:0] kr4_s;
	logic signed [61:0] kr6_s;
	logic signed [63:0] rad_full;
	logic signed [32:0] rad_s;

	assign rad_full = 64'sd65536 + lpcp_pkg::rnd_haz(64'(kr2_s) + 64'(kr4_s) + 64'(kr6_s),
		lpcp_pkg::COEF_FRAC);

	always_ff @(posedge clk) begin
		if (go[ST_KP]) begin
			kr2_s <= 44'(k1) * 44'(r2_s[ST_R6]);
			kr4_s <= 52'(k2) * 52'(r4_s[ST_R6]);
			kr6_s <= 62'(k3) * 62'(r6_s);
		end
		if (go[ST_RAD]) begin
			if (rad_full > lpcp_pkg::RADIAL_LIMIT)
				rad_s <= 33'(lpcp_pkg::RADIAL_LIMIT);
			else if (rad_full < -lpcp_pkg::RADIAL_LIMIT)
				rad_s <= 33'(-lpcp_pkg::RADIAL_LIMIT);
			else
				rad_s <= 33'(rad_full);
		end
	end

	// Distortion products and distorted coordinates.
	logic signed [53:0] xr_s, yr_s;
	logic signed [43:0] p1xy2_s, p2xy2_s;
	logic signed [45:0] p2tx_s, p1ty_s;
	logic signed [37:0] xd_s, yd_s;

	always_ff @(posedge clk) begin
		if (go[ST_DP]) begin
			xr_s    <= 54'(nrm_s[ST_DP-1].x) * 54'(rad_s);
			yr_s    <= 54'(nrm_s[ST_DP-1].y) * 54'(rad_s);
			p1xy2_s <= (44'(p1) * 44'(xy_s[ST_DP-1])) <<< 1;
			p2xy2_s <= (44'(p2) * 44'(xy_s[ST_DP-1])) <<< 1;
			p2tx_s  <= 46'(p2) * 46'(tng_s[ST_DP-1].tx);
			p1ty_s  <= 46'(p1) * 46'(tng_s[ST_DP-1].ty);
		end
		if (go[ST_XD]) begin
			xd_s <= 38'(lpcp_pkg::rnd_haz(64'(xr_s), lpcp_pkg::NORM_FRAC)
				+ lpcp_pkg::rnd_haz(64'(p1xy2_s), lpcp_pkg::COEF_FRAC)
				+ lpcp_pkg::rnd_haz(64'(p2tx_s), lpcp_pkg::COEF_FRAC));
			yd_s <= 38'(lpcp_pkg::rnd_haz(64'(yr_s), lpcp_pkg::NORM_FRAC)
				+ lpcp_pkg::rnd_haz(64'(p1ty_s), lpcp_pkg::COEF_FRAC)
				+ lpcp_pkg::rnd_haz(64'(p2xy2_s), lpcp_pkg::COEF_FRAC));
		end
	end

	// Intrinsics and pixel rounding.
	logic signed [55:0] fxd_s, fyd_s;
	logic signed [35:0] u_s, v_s;

	always_ff @(posedge clk) begin
		if (go[ST_FP]) begin
			fxd_s <= 56'(signed'({1'b0, fx})) * 56'(xd_s);
			fyd_s <= 56'(signed'({1'b0, fy})) * 56'(yd_s);
		end
		if (go[ST_PIX]) begin
			u_s <= 36'(lpcp_pkg::rnd_haz(64'(fxd_s) + signed'(64'({cx, 16'b0})),
				lpcp_pkg::NORM_FRAC + lpcp_pkg::INTR_FRAC));
			v_s <= 36'(lpcp_pkg::rnd_haz(64'(fyd_s) + signed'(64'({cy, 16'b0})),
				lpcp_pkg::NORM_FRAC + lpcp_pkg::INTR_FRAC));
		end
	end

	// Output register.
	logic                  hit;
	logic [3*PW-1:0]       pt_q;
	logic [PIXEL_BITS-1:0] pu_q, pv_q;
	logic                  hit_q;

	assign hit = side_s[ST_PIX].front
		&& !u_s[35] && u_s < signed'(36'(img_w))
		&& !v_s[35] && v_s < signed'(36'(img_h));
	assign emit = hit || keep;

	always_ff @(posedge clk) begin
		if (go[NS]) begin
			pt_q  <= side_s[ST_PIX].pt;
			pu_q  <= hit ? u_s[PIXEL_BITS-1:0] : '0;
			pv_q  <= hit ? v_s[PIXEL_BITS-1:0] : '0;
			hit_q <= hit;
		end
	end

	assign m_tvalid   = vld[NS];
	assign m_tdata    = TDATA_W'({pv_q, pu_q, pt_q});
	assign m_tuser[0] = hit_q;

	// A hit never carries a pixel outside the image.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && hit_q |-> pu_q < img_w && pv_q < img_h)
		else $error("hit result with pixel outside the image");

	// A miss leaves only with keep-uncolored and with zero pixel fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !hit_q |-> keep && pu_q == '0 && pv_q == '0)
		else $error("miss result emitted without keep-uncolored or with a pixel");

	// With the output stage empty the whole pipeline can move, so input is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		!vld[NS] |-> s_tready)
		else $error("input stalled while output stage is empty");

	// A result appears only from an item that was in the last compute stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(vld[NS-1]))
		else $error("result appeared without a preceding item");

endmodule
